>>> sv/gws_pkg.sv
// Package for the eight-direction grid word search.
// Payload structs, action and register codes, direction step table.
// No dependencies.
package gws_pkg;

	// action codes of an input transaction
	localparam logic [1:0] ACT_CELL = 2'd0;
	localparam logic [1:0] ACT_WORD = 2'd1;
	localparam logic [1:0] ACT_TEST = 2'd2;

	// configuration register indexes
	localparam logic [1:0] REG_GRID_ROWS   = 2'd0;
	localparam logic [1:0] REG_GRID_COLS   = 2'd1;
	localparam logic [1:0] REG_WORD_LENGTH = 2'd2;

	localparam int NUM_DIRS = 8;

	// per-axis step kind of a direction
	localparam logic [1:0] STEP_ZERO  = 2'd0;
	localparam logic [1:0] STEP_PLUS  = 2'd1;
	localparam logic [1:0] STEP_MINUS = 2'd2;

	// order E W S N SE SW NE NW
	localparam logic [1:0] DIR_ROW_STEP [NUM_DIRS] = '{
		STEP_ZERO, STEP_ZERO, STEP_PLUS, STEP_MINUS,
		STEP_PLUS, STEP_PLUS, STEP_MINUS, STEP_MINUS
	};
	localparam logic [1:0] DIR_COL_STEP [NUM_DIRS] = '{
		STEP_PLUS, STEP_MINUS, STEP_ZERO, STEP_ZERO,
		STEP_PLUS, STEP_MINUS, STEP_PLUS, STEP_MINUS
	};

	typedef struct packed {
		logic [1:0] action;
		logic [5:0] row;
		logic [5:0] col;
		logic [5:0] word_index;
		logic [7:0] char_value;
	} gws_in_t;

	typedef struct packed {
		logic [5:0] start_row;
		logic [5:0] start_col;
		logic [7:0] match_mask;
		logic       any_match;
	} gws_out_t;

	// walker control from the sequencer
	typedef struct packed {
		logic load;
		logic step;
	} gws_walk_ctl_t;

endpackage

>>> sv/gws_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module gws_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

>>> sv/gws_walker.sv
// Coordinate walker: running row/col positions and row bases for the eight
// directions, giving one grid address and one in-grid flag per direction.
// Depends on gws_pkg.
module gws_walker #(
	parameter int MAX_COLS = 64,
	parameter int PW       = 10,
	parameter int GAW      = 12
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  gws_pkg::gws_walk_ctl_t ctl,
	input  logic [5:0]            row,
	input  logic [5:0]            col,
	input  logic [GAW-1:0]        row_base,
	input  logic [PW-1:0]         rows_lim,
	input  logic [PW-1:0]         cols_lim,
	output logic [GAW-1:0]        addr [gws_pkg::NUM_DIRS],
	output logic [gws_pkg::NUM_DIRS-1:0] inb
);

	localparam logic [GAW-1:0] COL_STRIDE = GAW'(MAX_COLS);

	logic signed [PW-1:0] r0_q, rp_q, rm_q, c0_q, cp_q, cm_q;
	logic [GAW-1:0]       b0_q, bp_q, bm_q;

	// coordinates are payload; only the load/step decode matters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			r0_q <= '0;
			rp_q <= '0;
			rm_q <= '0;
			c0_q <= '0;
			cp_q <= '0;
			cm_q <= '0;
			b0_q <= '0;
			bp_q <= '0;
			bm_q <= '0;
		end else if (ctl.load) begin
			r0_q <= PW'(row);
			rp_q <= PW'(row);
			rm_q <= PW'(row);
			c0_q <= PW'(col);
			cp_q <= PW'(col);
			cm_q <= PW'(col);
			b0_q <= row_base;
			bp_q <= row_base;
			bm_q <= row_base;
		end else if (ctl.step) begin
			rp_q <= rp_q + PW'(1);
			rm_q <= rm_q - PW'(1);
			cp_q <= cp_q + PW'(1);
			cm_q <= cm_q - PW'(1);
			bp_q <= bp_q + COL_STRIDE;
			bm_q <= bm_q - COL_STRIDE;
		end
	end

	always_comb begin
		logic signed [PW-1:0] r_sel;
		logic signed [PW-1:0] c_sel;
		logic [GAW-1:0]       b_sel;
		for (int d = 0; d < gws_pkg::NUM_DIRS; d++) begin
			unique case (gws_pkg::DIR_ROW_STEP[d])
				gws_pkg::STEP_PLUS: begin
					r_sel = rp_q;
					b_sel = bp_q;
				end
				gws_pkg::STEP_MINUS: begin
					r_sel = rm_q;
					b_sel = bm_q;
				end
				default: begin
					r_sel = r0_q;
					b_sel = b0_q;
				end
			endcase
			unique case (gws_pkg::DIR_COL_STEP[d])
				gws_pkg::STEP_PLUS:  c_sel = cp_q;
				gws_pkg::STEP_MINUS: c_sel = cm_q;
				default:             c_sel = c0_q;
			endcase
			addr[d] = b_sel + GAW'(c_sel);
			inb[d]  = !r_sel[PW-1] && ($unsigned(r_sel) < rows_lim) &&
			          !c_sel[PW-1] && ($unsigned(c_sel) < cols_lim);
		end
	end

endmodule

>>> sv/grid_word_search_eight_dir.sv
// Top level of the eight-direction grid word search: config registers,
// sequencer, shared 8-lane byte compare, grid/word stores, output register.
// Depends on gws_pkg, gws_ram, gws_walker.
//
//  channel | signals                                  | direction | notes
//  --------+------------------------------------------+-----------+---------------------------
//  in      | in_valid, in_ready, in_data (gws_in_t)   | to block  | cell write, word write, test
//  out     | out_valid, out_ready, out_data (gws_out_t)| from block| one per test transaction
//  cfg     | cfg_valid, cfg_ready, cfg_index, cfg_data| to block  | always ready, 7-bit data
//
// Cell and word writes leave the sequencer idle; in_ready stays high.
// A test transaction holds in_ready low while the sequencer runs: in the
// RUN state each word character is issued, all eight directions reading
// their own grid RAM copy at once and the word RAM once, then DRAIN waits
// for the registered RAM reads and FINISH loads the output register.
// If the output register is still full, the sequencer waits in its last
// state until out_ready frees it; the next test starts after that.
// Reset clears control state and restores the registers (64, 64, 1); the
// stores keep their contents undefined until written.
module grid_word_search_eight_dir #(
	parameter int MAX_ROWS = 64,
	parameter int MAX_COLS = 64,
	parameter int MAX_WORD = 64
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  gws_pkg::gws_in_t  in_data,
	output logic              out_valid,
	input  logic              out_ready,
	output gws_pkg::gws_out_t out_data,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [1:0]        cfg_index,
	input  logic [6:0]        cfg_data
);

	localparam int GDEPTH = MAX_ROWS * MAX_COLS;
	localparam int GAW    = $clog2(GDEPTH);
	localparam int WAW    = MAX_WORD > 1 ? $clog2(MAX_WORD) : 1;
	localparam int KW     = $clog2(MAX_WORD + 1);           // holds MAX_WORD itself
	localparam int LW     = KW > 7 ? KW : 7;                // register compare width
	localparam int PW     = LW + 2;                         // signed coordinate width
	localparam int DW     = 9;                              // holds MAX_ROWS/MAX_COLS
	localparam int ND     = gws_pkg::NUM_DIRS;

	// sequencer states
	localparam logic [1:0] ST_IDLE   = 2'd0;
	localparam logic [1:0] ST_RUN    = 2'd1;
	localparam logic [1:0] ST_DRAIN  = 2'd2;
	localparam logic [1:0] ST_FINISH = 2'd3;

	logic [1:0] state_q;
	logic [6:0] grid_rows_q, grid_cols_q, word_length_q;

	logic [KW-1:0] k_q;
	logic [ND-1:0] mask_q;
	logic [5:0]    srow_q, scol_q;

	// stage 1: compare side of the registered RAM reads
	logic          v_s1, last_s1;
	logic [ND-1:0] inb_s1;

	logic              out_valid_q;
	gws_pkg::gws_out_t out_q;

	//------------------------------------------------------------------
	// Handshakes and decode
	//------------------------------------------------------------------
	logic in_acc, is_test, cell_we, word_we, issue, last_issue, out_load;

	assign in_ready  = (state_q == ST_IDLE);
	assign cfg_ready = 1'b1;
	assign in_acc    = in_valid && in_ready;
	assign is_test   = in_acc && (in_data.action == gws_pkg::ACT_TEST);

	// out-of-range writes are dropped
	assign cell_we = in_acc && (in_data.action == gws_pkg::ACT_CELL) &&
	                 (DW'(in_data.row) < DW'(MAX_ROWS)) &&
	                 (DW'(in_data.col) < DW'(MAX_COLS));
	assign word_we = in_acc && (in_data.action == gws_pkg::ACT_WORD) &&
	                 (LW'(in_data.word_index) < LW'(MAX_WORD));

	// row base shared by the cell write address and the walker load
	logic [GAW-1:0] row_base, cell_waddr;
	assign row_base   = GAW'(in_data.row) * GAW'(MAX_COLS);
	assign cell_waddr = row_base + GAW'(in_data.col);

	//------------------------------------------------------------------
	// Effective limits: saturate at the maxima, word length zero as one
	//------------------------------------------------------------------
	logic [LW-1:0] wl_w;
	logic [KW-1:0] len_eff;
	logic [PW-1:0] rows_lim, cols_lim;

	assign wl_w = LW'(word_length_q);

	always_comb begin
		if (wl_w > LW'(MAX_WORD)) begin
			len_eff = KW'(MAX_WORD);
		end else if (wl_w == '0) begin
			len_eff = KW'(1);
		end else begin
			len_eff = KW'(wl_w);
		end
	end

	assign rows_lim = (PW'(grid_rows_q) > PW'(MAX_ROWS)) ? PW'(MAX_ROWS) : PW'(grid_rows_q);
	assign cols_lim = (PW'(grid_cols_q) > PW'(MAX_COLS)) ? PW'(MAX_COLS) : PW'(grid_cols_q);

	assign issue      = (state_q == ST_RUN);
	assign last_issue = issue && (k_q == len_eff - KW'(1));
	assign out_load   = (state_q == ST_FINISH) && (!out_valid_q || out_ready);

	//------------------------------------------------------------------
	// Walker and stores
	//------------------------------------------------------------------
	gws_pkg::gws_walk_ctl_t walk_ctl;
	logic [GAW-1:0]         grid_raddr [ND];
	logic [ND-1:0]          inb;
	logic [7:0]             grid_rdata [ND];
	logic [7:0]             word_rdata;

	assign walk_ctl.load = is_test;
	assign walk_ctl.step = issue;

	gws_walker #(
		.MAX_COLS (MAX_COLS),
		.PW       (PW),
		.GAW      (GAW)
	) u_walker (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (walk_ctl),
		.row      (in_data.row),
		.col      (in_data.col),
		.row_base (row_base),
		.rows_lim (rows_lim),
		.cols_lim (cols_lim),
		.addr     (grid_raddr),
		.inb      (inb)
	);

	// one grid copy per direction so all eight read in the same cycle
	for (genvar d = 0; d < ND; d++) begin : g_grid
		gws_ram #(
			.WIDTH (8),
			.DEPTH (GDEPTH)
		) u_grid_ram (
			.clk   (clk),
			.we    (cell_we),
			.waddr (cell_waddr),
			.wdata (in_data.char_value),
			.raddr (grid_raddr[d]),
			.rdata (grid_rdata[d])
		);
	end

	gws_ram #(
		.WIDTH (8),
		.DEPTH (MAX_WORD)
	) u_word_ram (
		.clk   (clk),
		.we    (word_we),
		.waddr (WAW'(in_data.word_index)),
		.wdata (in_data.char_value),
		.raddr (WAW'(k_q)),
		.rdata (word_rdata)
	);

	// shared compare: eight byte lanes against the current word character
	logic [ND-1:0] eq;
	always_comb begin
		for (int d = 0; d < ND; d++) begin
			eq[d] = (grid_rdata[d] == word_rdata);
		end
	end

	//------------------------------------------------------------------
	// Config registers
	//------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_rows_q   <= 7'd64;
			grid_cols_q   <= 7'd64;
			word_length_q <= 7'd1;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				gws_pkg::REG_GRID_ROWS:   grid_rows_q   <= cfg_data;
				gws_pkg::REG_GRID_COLS:   grid_cols_q   <= cfg_data;
				gws_pkg::REG_WORD_LENGTH: word_length_q <= cfg_data;
				default: ;
			endcase
		end
	end

	//------------------------------------------------------------------
	// Sequencer
	//------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			k_q     <= '0;
			v_s1    <= 1'b0;
			last_s1 <= 1'b0;
			inb_s1  <= '0;
			mask_q  <= '0;
			srow_q  <= '0;
			scol_q  <= '0;
		end else begin
			v_s1    <= issue;
			last_s1 <= last_issue;
			inb_s1  <= inb;

			if (v_s1) begin
				mask_q <= mask_q & inb_s1 & eq;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (is_test) begin
						state_q <= ST_RUN;
						k_q     <= '0;
						mask_q  <= '1;
						srow_q  <= in_data.row;
						scol_q  <= in_data.col;
					end
				end
				ST_RUN: begin
					k_q <= k_q + KW'(1);
					if (last_issue) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					state_q <= ST_FINISH;
				end
				ST_FINISH: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	//------------------------------------------------------------------
	// Output register
	//------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_q.start_row  <= srow_q;
			out_q.start_col  <= scol_q;
			out_q.match_mask <= mask_q;
			out_q.any_match  <= |mask_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	//------------------------------------------------------------------
	// Assertions
	//------------------------------------------------------------------
	a_s1_only_busy: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 |-> (state_q == ST_RUN || state_q == ST_DRAIN))
		else $error("compare stage active outside a walk");

	a_drain_last: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DRAIN) |-> (v_s1 && last_s1))
		else $error("drain without the last character in flight");

	a_test_starts: assert property (@(posedge clk) disable iff (!arst_n)
		is_test |=> (state_q == ST_RUN && k_q == '0 && mask_q == '1))
		else $error("test transaction did not start a walk");

	a_mask_falls: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |=> ((mask_q & ~$past(mask_q)) == '0))
		else $error("match bit set again during a walk");

	a_any_match: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (out_q.any_match == (out_q.match_mask != '0)))
		else $error("any_match disagrees with match_mask");

endmodule
